[rtl/core/zero_sum_subarray_counter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Zero-sum subarray counter: assertion macros
// Shared property wrappers, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ZERO_SUM_SUBARRAY_COUNTER_UNIT_DEFINES_SVH
`define ZERO_SUM_SUBARRAY_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication
`define ZSSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ZSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/zssc_pkg.sv]
// ----------------------------------------------------------------------------
// zssc_pkg
// Sizes, types and helpers shared by the zero-sum subarray counter.
// ----------------------------------------------------------------------------
`default_nettype none

package zssc_pkg;

    localparam int TABLE_ENTRIES  = 1024;
    localparam int ELEMENT_BITS   = 32;
    localparam int KEY_BITS       = 48;
    localparam int COUNT_BITS     = 11;
    localparam int ANSWER_BITS    = 20;
    localparam int SEEN_BITS      = $clog2(TABLE_ENTRIES + 1);
    localparam int IN_TDATA_BITS  = 32;
    localparam int OUT_TDATA_BITS = ((ANSWER_BITS + 7) / 8) * 8;

    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [ANSWER_BITS-1:0] answer_t;
    typedef logic [SEEN_BITS-1:0]   seen_t;

    localparam count_t  COUNT_MAX  = '1;
    localparam answer_t ANSWER_MAX = '1;
    localparam key_t    ELEMENT_MASK = key_t'((64'd1 << ELEMENT_BITS) - 64'd1);

    // one lookup travelling down the cell chain
    typedef struct packed {
        logic   valid;
        logic   last;
        logic   done;
        count_t cnt;
        key_t   key;
    } query_t;

    // low ELEMENT_BITS of the beat, sign-extended to the key width
    function automatic key_t extend_element(input logic [IN_TDATA_BITS-1:0] v);
        key_t raw;
        raw = key_t'(v) & ELEMENT_MASK;
        return raw[ELEMENT_BITS-1] ? (raw | ~ELEMENT_MASK) : raw;
    endfunction

endpackage

`default_nettype wire

[rtl/core/zero_sum_subarray_counter_unit.sv]
// ----------------------------------------------------------------------------
// zero_sum_subarray_counter_unit
// Streaming counter of zero-sum subarrays over prefix-sum occurrences.
// ----------------------------------------------------------------------------
// Each input beat is one signed element; the beat with tlast closes the array.
// The prefix sum is formed at the input register and sent as a lookup down a
// chain of TABLE_ENTRIES cells, each cell holding one (sum, count) entry and
// moving the lookup on by one cell per cycle while the output is not stalled.
// A new beat is accepted every cycle unless the output stalls; each result
// beat comes out through the input register (loaded on the accepting edge),
// then one register per cell and one at the output, so its delay is set by
// the length of the cell chain. A stall on the output holds the whole chain.
// Table clearing at the end of an array rides along with the last lookup, so
// no clearing pass and no dead time between arrays. Arrays longer than
// TABLE_ENTRIES - 1 elements raise the overflow flag in tuser.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_sum_subarray_counter_unit
    import zssc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // [31:0] element_value
    input  wire logic                      s_tlast,
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    output      logic [OUT_TDATA_BITS-1:0] m_tdata,   // [19:0] zero_sum_count
    output      logic                      m_tlast,
    output      logic [0:0]                m_tuser    // [0] capacity_overflow
);

    logic    advance;
    key_t    running_sum_reg, running_sum_next;
    key_t    new_sum;
    query_t  entry_q_reg,     entry_q_next;
    query_t  chain_q [TABLE_ENTRIES+1];
    answer_t out_count;

    // whole pipeline moves when the output beat is empty or being taken
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign new_sum  = running_sum_reg + extend_element(s_tdata);

    always_comb begin
        running_sum_next = running_sum_reg;
        entry_q_next     = entry_q_reg;
        if (advance) begin
            entry_q_next.valid = s_tvalid;
            entry_q_next.last  = s_tlast;
            entry_q_next.done  = 1'b0;
            entry_q_next.cnt   = '0;
            entry_q_next.key   = new_sum;
            if (s_tvalid) begin
                running_sum_next = s_tlast ? '0 : new_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg   <= '0;
            entry_q_reg.valid <= 1'b0;
        end else begin
            running_sum_reg <= running_sum_next;
            entry_q_reg     <= entry_q_next;
        end
    end

    assign chain_q[0] = entry_q_reg;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        zssc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .is_head (1'(g == 0)),
            .q_in    (chain_q[g]),
            .q_out   (chain_q[g+1])
        );
    end

    zssc_tally u_tally (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .q_in         (chain_q[TABLE_ENTRIES]),
        .out_valid    (m_tvalid),
        .out_count    (out_count),
        .out_last     (m_tlast),
        .out_overflow (m_tuser[0])
    );

    assign m_tdata = OUT_TDATA_BITS'(out_count);

endmodule

`default_nettype wire

[rtl/core/zssc_cell.sv]
// ----------------------------------------------------------------------------
// zssc_cell
// One table entry plus one stage of the lookup chain. A passing lookup either
// hits the stored sum, claims the entry if it is empty, or moves on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_sum_subarray_counter_unit_defines.svh"

module zssc_cell
    import zssc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   advance,
    input  wire logic   is_head,
    input  wire query_t q_in,
    output      query_t q_out
);

    logic   entry_valid_reg, entry_valid_next;
    key_t   entry_key_reg,   entry_key_next;
    count_t entry_count_reg, entry_count_next;
    query_t q_out_reg,       q_out_next;

    logic hit;
    logic claim;

    assign hit   = q_in.valid && !q_in.done && entry_valid_reg && (entry_key_reg == q_in.key);
    assign claim = q_in.valid && !q_in.done && !entry_valid_reg;

    always_comb begin
        entry_valid_next = entry_valid_reg;
        entry_key_next   = entry_key_reg;
        entry_count_next = entry_count_reg;
        q_out_next       = q_out_reg;
        if (advance) begin
            q_out_next = q_in;
            if (hit) begin
                q_out_next.done = 1'b1;
                q_out_next.cnt  = entry_count_reg;
                if (entry_count_reg != COUNT_MAX) begin
                    entry_count_next = entry_count_reg + count_t'(1);
                end
            end
            if (claim) begin
                q_out_next.done  = 1'b1;
                q_out_next.cnt   = '0;
                entry_valid_next = 1'b1;
                entry_key_next   = q_in.key;
                entry_count_next = count_t'(1);
            end
            // end of array: the head re-seeds sum zero, the rest empty out
            if (q_in.valid && q_in.last) begin
                entry_valid_next = is_head;
                entry_key_next   = '0;
                entry_count_next = count_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= is_head;
            entry_key_reg   <= '0;
            entry_count_reg <= count_t'(1);
            q_out_reg.valid <= 1'b0;
        end else begin
            entry_valid_reg <= entry_valid_next;
            entry_key_reg   <= entry_key_next;
            entry_count_reg <= entry_count_next;
            q_out_reg       <= q_out_next;
        end
    end

    assign q_out = q_out_reg;

    `ZSSC_ASSERT_NEXT(a_clear_on_last, advance && q_in.valid && q_in.last, entry_valid_reg == is_head, "cell not cleared after last beat")
    `ZSSC_ASSERT_NOW(a_count_nonzero, entry_valid_reg, entry_count_reg != '0, "valid entry with zero count")

endmodule

`default_nettype wire

[rtl/core/zssc_tally.sv]
// ----------------------------------------------------------------------------
// zssc_tally
// End of the chain: accumulates the matched counts into the saturating
// answer, tracks array length and overflow, and holds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zero_sum_subarray_counter_unit_defines.svh"

module zssc_tally
    import zssc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    advance,
    input  wire query_t  q_in,
    output      logic    out_valid,
    output      answer_t out_count,
    output      logic    out_last,
    output      logic    out_overflow
);

    localparam int SUM_BITS = ANSWER_BITS + 1;

    seen_t   seen_reg,         seen_next;
    logic    overflow_reg,     overflow_next;
    answer_t answer_reg,       answer_next;
    logic    out_valid_reg,    out_valid_next;
    answer_t out_count_reg,    out_count_next;
    logic    out_last_reg,     out_last_next;
    logic    out_overflow_reg, out_overflow_next;

    logic                ovf_now;
    seen_t               seen_bump;
    logic [SUM_BITS-1:0] ans_sum;
    answer_t             ans_new;

    assign ovf_now   = overflow_reg || (seen_reg >= seen_t'(TABLE_ENTRIES - 1));
    assign seen_bump = (seen_reg < seen_t'(TABLE_ENTRIES)) ? seen_reg + seen_t'(1) : seen_reg;
    assign ans_sum   = SUM_BITS'(answer_reg) + SUM_BITS'(q_in.cnt);
    assign ans_new   = (ans_sum >= SUM_BITS'(ANSWER_MAX)) ? ANSWER_MAX
                                                          : ans_sum[ANSWER_BITS-1:0];

    always_comb begin
        seen_next         = seen_reg;
        overflow_next     = overflow_reg;
        answer_next       = answer_reg;
        out_valid_next    = out_valid_reg;
        out_count_next    = out_count_reg;
        out_last_next     = out_last_reg;
        out_overflow_next = out_overflow_reg;
        if (advance) begin
            out_valid_next = q_in.valid;
            if (q_in.valid) begin
                out_count_next    = ans_new;
                out_last_next     = q_in.last;
                out_overflow_next = ovf_now;
                if (q_in.last) begin
                    seen_next     = '0;
                    overflow_next = 1'b0;
                    answer_next   = '0;
                end else begin
                    seen_next     = seen_bump;
                    overflow_next = ovf_now;
                    answer_next   = ans_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            overflow_reg  <= 1'b0;
            answer_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            seen_reg         <= seen_next;
            overflow_reg     <= overflow_next;
            answer_reg       <= answer_next;
            out_valid_reg    <= out_valid_next;
            out_count_reg    <= out_count_next;
            out_last_reg     <= out_last_next;
            out_overflow_reg <= out_overflow_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_count    = out_count_reg;
    assign out_last     = out_last_reg;
    assign out_overflow = out_overflow_reg;

    `ZSSC_ASSERT_NOW(a_ovf_len, overflow_reg, seen_reg == seen_t'(TABLE_ENTRIES), "overflow flag without full length")
    `ZSSC_ASSERT_NEXT(a_sat_hold, (answer_reg == ANSWER_MAX) && advance && q_in.valid && !q_in.last, answer_reg == ANSWER_MAX, "saturated answer dropped")

endmodule

`default_nettype wire
